### src/netf_pkg.sv
// Shared types, constants and helpers for the nested escaped token finder.
// No dependencies; imported by every module of the block.
package netf_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_INDEX_BITS      = 16;
    localparam int DEF_MAX_TOKEN_BYTES = 8;

    // Fixed geometry
    localparam int WIN_DEPTH     = 8;
    localparam int MAX_TAG_BYTES = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [7:0] ESC_BYTE = 8'h5C;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_TOKEN_BYTES  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOKEN_LENGTH = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_NEST_START   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_NEST_END     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_TAG_LENGTHS  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SEARCH_MODE  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_FROM_INDEX   = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_TO_INDEX     = 3'd7;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Result of one scan step
    typedef enum logic [1:0] {
        OC_CONTINUE,
        OC_STALL,
        OC_HALT,
        OC_MATCH
    } outcome_t;

    typedef struct packed {
        logic accept;   // load the incoming item
        logic step;     // apply one scan step
        logic finish;   // close the item: emit result, clear on last
    } cmd_t;

    typedef struct packed {
        outcome_t outcome;
        logic     active;   // search neither matched nor halted
        logic     pending;  // finishing now produces a result
        logic     out_busy; // output register full and not taken
    } status_t;

    // Lead byte of a double-byte character
    function automatic logic is_lead(input logic [7:0] b);
        return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
    endfunction

    // Tag length saturated to the tag width
    function automatic logic [1:0] sat_tag(input logic [1:0] l);
        return (l > 2'(MAX_TAG_BYTES)) ? 2'(MAX_TAG_BYTES) : l;
    endfunction

endpackage

### src/nested_escaped_token_finder_unit.sv
// Top level of the nested escaped token finder: controller plus datapath.
// Depends on netf_pkg, netf_ctrl and netf_dp.
//
//  channel | signals                          | item
//  s_      | s_tvalid s_tready s_tdata s_tlast | one source byte, tlast = last byte
//  m_      | m_tvalid m_tready m_tdata m_tuser | one search result, tuser = found
//  cfg_    | cfg_we cfg_index cfg_data         | one register write
//
// Each byte is accepted, then scanned for as many steps as the byte allows
// (each step moves the scan 1 to 3 bytes), then finished. On the last byte
// the scan does not stall and runs to a match or the search range end.
// Reset (aresetn, synchronous, active low) clears control state and config.
// A result waits in an output register; a second result stalls the finish.
module nested_escaped_token_finder_unit #(
    parameter int INDEX_BITS      = netf_pkg::DEF_INDEX_BITS,
    parameter int MAX_TOKEN_BYTES = netf_pkg::DEF_MAX_TOKEN_BYTES
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // src_byte
    input  logic                               s_tlast,   // last_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,   // match_index
    output logic                               m_tuser,   // found
    input  logic                               cfg_we,
    input  logic [netf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [netf_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import netf_pkg::*;

    cmd_t    cmd;
    status_t status;

    netf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    netf_dp #(
        .INDEX_BITS      (INDEX_BITS),
        .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_byte    (s_tdata),
        .s_last    (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### src/netf_ctrl.sv
// Controller for the token finder: sequences accept, scan steps and finish.
// Depends on netf_pkg.
module netf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  netf_pkg::status_t status,
    output netf_pkg::cmd_t    cmd
);
    import netf_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (!(status.active && status.outcome == OC_CONTINUE) &&
                    !(status.pending && status.out_busy)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs; nothing is taken while reset is held
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = aresetn;
                cmd.accept = s_tvalid && aresetn;
            end
            ST_SCAN: begin
                if (status.active && status.outcome == OC_CONTINUE) begin
                    cmd.step = 1'b1;
                end else if (!(status.pending && status.out_busy)) begin
                    cmd.finish = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

### src/netf_dp.sv
// Datapath for the token finder: config registers, lookahead window,
// scan position, nesting depth and the result register. Depends on netf_pkg.
module netf_dp #(
    parameter int INDEX_BITS      = netf_pkg::DEF_INDEX_BITS,
    parameter int MAX_TOKEN_BYTES = netf_pkg::DEF_MAX_TOKEN_BYTES
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [netf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [netf_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic [7:0]                         s_byte,
    input  logic                               s_last,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,
    output logic                               m_tuser,
    input  netf_pkg::cmd_t                     cmd,
    output netf_pkg::status_t                  status
);
    import netf_pkg::*;

    // Position width: room for 16-bit indexes plus a short overrun
    localparam int PW = ((INDEX_BITS > 16) ? INDEX_BITS : 16) + 2;
    localparam logic [INDEX_BITS-1:0] LEN_MAX = {INDEX_BITS{1'b1}};

    // Configuration registers
    logic [63:0] tok_reg;
    logic [3:0]  tok_len_reg;
    logic [15:0] start_tag_reg, end_tag_reg;
    logic [3:0]  tag_len_reg;
    logic [1:0]  mode_reg;
    logic [15:0] from_reg, to_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg       <= '0;
            tok_len_reg   <= 4'd1;
            start_tag_reg <= '0;
            end_tag_reg   <= '0;
            tag_len_reg   <= '0;
            mode_reg      <= '0;
            from_reg      <= '0;
            to_reg        <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TOKEN_BYTES:  tok_reg       <= cfg_data;
                REG_TOKEN_LENGTH: tok_len_reg   <= cfg_data[3:0];
                REG_NEST_START:   start_tag_reg <= cfg_data[15:0];
                REG_NEST_END:     end_tag_reg   <= cfg_data[15:0];
                REG_TAG_LENGTHS:  tag_len_reg   <= cfg_data[3:0];
                REG_SEARCH_MODE:  mode_reg      <= cfg_data[1:0];
                REG_FROM_INDEX:   from_reg      <= cfg_data[15:0];
                REG_TO_INDEX:     to_reg        <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Search state
    logic [7:0]            win_reg [WIN_DEPTH];
    logic [INDEX_BITS-1:0] bp_reg;
    logic [PW-1:0]         scan_reg;
    logic [15:0]           depth_reg;
    logic                  done_reg, halted_reg, last_reg;
    logic                  valid_reg, found_reg;
    logic [15:0]           idx_reg;

    // Derived config
    logic          nest, esc;
    logic [1:0]    sl, el;
    logic [3:0]    tl, w;
    logic [PW-1:0] bp_ext, tl_ext;

    always_comb begin
        nest   = mode_reg[0];
        esc    = mode_reg[1];
        sl     = sat_tag(tag_len_reg[1:0]);
        el     = sat_tag(tag_len_reg[3:2]);
        tl     = (tok_len_reg > 4'(MAX_TOKEN_BYTES)) ? 4'(MAX_TOKEN_BYTES) : tok_len_reg;
        w      = (tl < 4'd2) ? 4'd2 : tl;
        bp_ext = PW'(bp_reg);
        tl_ext = PW'(tl);
    end

    // Window lanes aligned to the scan position; unreceived bytes read zero
    logic [7:0] lane [WIN_DEPTH];

    always_comb begin
        for (int k = 0; k < WIN_DEPTH; k++) begin
            if (scan_reg + PW'(k) < bp_ext) begin
                lane[k] = win_reg[3'(scan_reg[2:0] + 3'(k))];
            end else begin
                lane[k] = 8'h00;
            end
        end
    end

    // One scan step
    outcome_t      outcome;
    logic [PW-1:0] end_pos, lim, p_next;
    logic [15:0]   depth_next;
    logic          start_hit, end_hit, tok_hit;

    always_comb begin
        start_hit = lane[0] == start_tag_reg[7:0] &&
                    (sl <= 2'd1 || lane[1] == start_tag_reg[15:8]);
        end_hit   = lane[0] == end_tag_reg[7:0] &&
                    (el <= 2'd1 || lane[1] == end_tag_reg[15:8]);
        tok_hit   = 1'b1;
        for (int k = 0; k < MAX_TOKEN_BYTES; k++) begin
            if (4'(k) < tl && lane[k] != tok_reg[8*k +: 8]) tok_hit = 1'b0;
        end
        lim     = bp_ext - tl_ext + PW'(1);
        end_pos = PW'(to_reg);
        if (last_reg && lim < end_pos) end_pos = lim;

        outcome    = OC_CONTINUE;
        depth_next = depth_reg;
        p_next     = scan_reg + (is_lead(lane[0]) ? PW'(2) : PW'(1));
        if (nest && (sl == 2'd0 || el == 2'd0)) begin
            outcome = OC_HALT;
        end else if (last_reg && bp_ext < tl_ext) begin
            outcome = OC_HALT;
        end else if (scan_reg >= end_pos) begin
            outcome = OC_HALT;
        end else if (!last_reg && bp_ext < scan_reg + PW'(w)) begin
            outcome = OC_STALL;
        end else if (esc && lane[0] == ESC_BYTE) begin
            p_next = scan_reg + (is_lead(lane[1]) ? PW'(3) : PW'(2));
        end else if (nest && start_hit) begin
            p_next = scan_reg + PW'(sl);
            if (depth_reg != 16'hFFFF) depth_next = depth_reg + 16'd1;
        end else if (nest && depth_reg != 16'd0 && end_hit) begin
            p_next     = scan_reg + PW'(el);
            depth_next = depth_reg - 16'd1;
        end else if (depth_reg == 16'd0 && tok_hit) begin
            outcome = OC_MATCH;
        end
    end

    // Status to the controller
    logic match_now;

    always_comb begin
        match_now       = !done_reg && !halted_reg && outcome == OC_MATCH;
        status.outcome  = outcome;
        status.active   = !done_reg && !halted_reg;
        status.pending  = match_now || (last_reg && !done_reg);
        status.out_busy = valid_reg && !m_tready;
    end

    // Accept-time view of the search state (a new search starts at the from index)
    logic          new_search, eff_done, eff_halt, win_wr;
    logic [PW-1:0] eff_scan;

    always_comb begin
        new_search = bp_reg == '0;
        eff_scan   = new_search ? PW'(from_reg) : scan_reg;
        eff_done   = new_search ? 1'b0 : done_reg;
        eff_halt   = new_search ? (from_reg == to_reg) : halted_reg;
        win_wr     = bp_reg != LEN_MAX && !eff_done && !eff_halt &&
                     bp_ext >= eff_scan && bp_ext < eff_scan + PW'(WIN_DEPTH);
    end

    // Window write
    always_ff @(posedge aclk) begin
        if (cmd.accept && win_wr) begin
            win_reg[bp_reg[2:0]] <= s_byte;
        end
    end

    // Search control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bp_reg     <= '0;
            scan_reg   <= '0;
            depth_reg  <= '0;
            done_reg   <= 1'b0;
            halted_reg <= 1'b0;
            last_reg   <= 1'b0;
        end else if (cmd.accept) begin
            last_reg   <= s_last;
            scan_reg   <= eff_scan;
            done_reg   <= eff_done;
            halted_reg <= eff_halt;
            if (new_search) depth_reg <= '0;
            if (bp_reg != LEN_MAX) bp_reg <= bp_reg + INDEX_BITS'(1);
        end else if (cmd.step) begin
            scan_reg  <= p_next;
            depth_reg <= depth_next;
        end else if (cmd.finish) begin
            if (match_now) done_reg <= 1'b1;
            if (status.active && outcome == OC_HALT) halted_reg <= 1'b1;
            if (last_reg) begin
                bp_reg     <= '0;
                depth_reg  <= '0;
                done_reg   <= 1'b0;
                halted_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.finish && status.pending) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish && status.pending) begin
            found_reg <= match_now;
            idx_reg   <= match_now ? scan_reg[15:0] : 16'd0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = idx_reg;
    assign m_tuser  = found_reg;

endmodule
